// ===== src/ttag_pkg.sv =====
// ----------------------------------------------------------------------------
// ttag_pkg
// Shared constants and types for the tiled texture address generator.
// ----------------------------------------------------------------------------
package ttag_pkg;

    localparam int TILE_SIDE_DEF = 32;
    localparam int MAX_SIDE_DEF  = 4096;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int SIDE_REG_W = 13;
    localparam int BPP_W      = 3;
    localparam int OFFSET_W   = 26;
    localparam int COUNT_W    = 24;

    localparam logic [SIDE_REG_W-1:0] WIDTH_RST  = SIDE_REG_W'(1);
    localparam logic [SIDE_REG_W-1:0] HEIGHT_RST = SIDE_REG_W'(1);
    localparam logic [BPP_W-1:0]      BPP_RST    = BPP_W'(4);
    localparam logic [BPP_W-1:0]      BPP_MAX    = BPP_W'(4);

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_BYTES_PER_PIXEL = 2'd2,
        REG_DIRECTION       = 2'd3
    } t_reg_idx;

endpackage

// ===== src/tiled_texture_address_generator.sv =====
// ----------------------------------------------------------------------------
// tiled_texture_address_generator
// Emits source/destination byte offset pairs that convert a texture between
// square-tile order and linear raster order, one pair per input beat.
// ----------------------------------------------------------------------------
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   in       | i_in_valid / o_in_ready    | i_restart
//   out      | o_out_valid / i_out_ready  | o_source_offset, o_dest_offset,
//            |                            | o_last
//   config   | psel, penable, pwrite,     | paddr, pwdata, prdata
//            | pready                     |
//
// One beat per cycle while the output is not stalled; a pair passes through the
// walk stage, row-multiply stage and pixel-size stage after its input beat.
// The walk position advances in the accept cycle, so the stages behind it
// only carry arithmetic. Each stage fills whenever the stage ahead of it is
// empty or moving, so bubbles collapse under output stall.
// Synchronous active-low reset clears the walk, the stage valids and loads
// the register defaults (1 x 1 image, 4 bytes per pixel, tile to linear).
// ----------------------------------------------------------------------------
module tiled_texture_address_generator #(
    parameter int TILE_SIDE = ttag_pkg::TILE_SIDE_DEF,
    parameter int MAX_SIDE  = ttag_pkg::MAX_SIDE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ttag_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ttag_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ttag_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ttag_pkg::OFFSET_W-1:0]   o_source_offset,
    output logic [ttag_pkg::OFFSET_W-1:0]   o_dest_offset,
    output logic                            o_last
);
    import ttag_pkg::*;

    localparam int NT  = (MAX_SIDE + TILE_SIDE - 1) / TILE_SIDE;
    localparam int CW  = $clog2(NT * TILE_SIDE);
    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int XW  = ((CW > SW) ? CW : SW) + 1;
    localparam int RW  = (SW > SIDE_REG_W) ? SW : SIDE_REG_W;
    localparam int PW  = XW + SW;
    localparam int TW  = COUNT_W + BPP_W;
    localparam int LW  = OFFSET_W + BPP_W;

    // configuration registers
    logic [SIDE_REG_W-1:0] r_image_width, r_image_height;
    logic [BPP_W-1:0]      r_bytes_per_pixel;
    logic                  r_direction;
    logic                  cfg_wr;
    t_reg_idx              cfg_idx;

    logic [SW-1:0]    width_c, height_c;
    logic [BPP_W-1:0] bpp_c;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= WIDTH_RST;
            r_image_height    <= HEIGHT_RST;
            r_bytes_per_pixel <= BPP_RST;
            r_direction       <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:     r_image_width     <= pwdata[SIDE_REG_W-1:0];
                REG_IMAGE_HEIGHT:    r_image_height    <= pwdata[SIDE_REG_W-1:0];
                REG_BYTES_PER_PIXEL: r_bytes_per_pixel <= pwdata[BPP_W-1:0];
                REG_DIRECTION:       r_direction       <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:     prdata = CFG_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT:    prdata = CFG_DATA_W'(r_image_height);
            REG_BYTES_PER_PIXEL: prdata = CFG_DATA_W'(r_bytes_per_pixel);
            REG_DIRECTION:       prdata = CFG_DATA_W'(r_direction);
            default:             prdata = '0;
        endcase
    end

    // clamp sides to 1..MAX_SIDE and pixel size to 1..4
    always_comb begin
        if (r_image_width == '0) begin
            width_c = SW'(1);
        end else if (RW'(r_image_width) > RW'(MAX_SIDE)) begin
            width_c = SW'(MAX_SIDE);
        end else begin
            width_c = SW'(r_image_width);
        end

        if (r_image_height == '0) begin
            height_c = SW'(1);
        end else if (RW'(r_image_height) > RW'(MAX_SIDE)) begin
            height_c = SW'(MAX_SIDE);
        end else begin
            height_c = SW'(r_image_height);
        end

        if (r_bytes_per_pixel == '0) begin
            bpp_c = BPP_W'(1);
        end else if (r_bytes_per_pixel > BPP_MAX) begin
            bpp_c = BPP_MAX;
        end else begin
            bpp_c = r_bytes_per_pixel;
        end
    end

    // stage enables
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic en_out, en_s2, en_s1, accept;

    assign en_out     = !r_out_valid || i_out_ready;
    assign en_s2      = !r_s2_valid || en_out;
    assign en_s1      = !r_s1_valid || en_s2;
    assign o_in_ready = en_s1;
    assign accept     = i_in_valid && en_s1;

    // walk
    logic [XW-1:0]      walk_px, walk_py;
    logic [COUNT_W-1:0] walk_count;
    logic               walk_last;

    ttag_walk #(
        .TILE_SIDE (TILE_SIDE),
        .MAX_SIDE  (MAX_SIDE),
        .SW        (SW),
        .XW        (XW)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_restart (i_restart),
        .i_width   (width_c),
        .i_height  (height_c),
        .o_px      (walk_px),
        .o_py      (walk_py),
        .o_count   (walk_count),
        .o_last    (walk_last)
    );

    // stage 1: position of the pixel
    logic [XW-1:0]      r_s1_px, r_s1_py;
    logic [COUNT_W-1:0] r_s1_count;
    logic               r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en_s1) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px    <= walk_px;
            r_s1_py    <= walk_py;
            r_s1_count <= walk_count;
            r_s1_last  <= walk_last;
        end
    end

    // stage 2: raster pixel index and tile-order byte offset
    logic [PW-1:0]       row_index;
    logic [TW-1:0]       til_full;
    logic [OFFSET_W-1:0] r_s2_lin_pix, r_s2_til;
    logic                r_s2_last;

    assign row_index = PW'(r_s1_py) * PW'(width_c) + PW'(r_s1_px);
    assign til_full  = TW'(r_s1_count) * TW'(bpp_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2 && r_s1_valid) begin
            r_s2_lin_pix <= OFFSET_W'(row_index);
            r_s2_til     <= til_full[OFFSET_W-1:0];
            r_s2_last    <= r_s1_last;
        end
    end

    // output register: scale raster index to bytes, route by direction
    logic [LW-1:0]       lin_full;
    logic [OFFSET_W-1:0] lin_off;
    logic [OFFSET_W-1:0] r_source_offset, r_dest_offset;
    logic                r_last;

    assign lin_full = LW'(r_s2_lin_pix) * LW'(bpp_c);
    assign lin_off  = lin_full[OFFSET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s2_valid) begin
            r_source_offset <= r_direction ? lin_off : r_s2_til;
            r_dest_offset   <= r_direction ? r_s2_til : lin_off;
            r_last          <= r_s2_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_source_offset = r_source_offset;
    assign o_dest_offset   = r_dest_offset;
    assign o_last          = r_last;

endmodule

// ===== src/ttag_walk.sv =====
// ----------------------------------------------------------------------------
// ttag_walk
// Tile-order pixel walk: current position, pixel count and final-pixel flag,
// advanced by one pixel on every accepted beat.
// ----------------------------------------------------------------------------
module ttag_walk #(
    parameter int TILE_SIDE = ttag_pkg::TILE_SIDE_DEF,
    parameter int MAX_SIDE  = ttag_pkg::MAX_SIDE_DEF,
    parameter int SW        = $clog2(MAX_SIDE + 1),
    parameter int XW        = SW + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_restart,
    input  logic [SW-1:0]               i_width,
    input  logic [SW-1:0]               i_height,
    output logic [XW-1:0]               o_px,
    output logic [XW-1:0]               o_py,
    output logic [ttag_pkg::COUNT_W-1:0] o_count,
    output logic                        o_last
);
    import ttag_pkg::*;

    localparam int TXW = $clog2(TILE_SIDE);
    localparam int NT  = (MAX_SIDE + TILE_SIDE - 1) / TILE_SIDE;
    localparam int TCW = (NT > 1) ? $clog2(NT) : 1;
    localparam logic [TXW:0]  TS_T = (TXW + 1)'(TILE_SIDE);
    localparam logic [XW-1:0] TS_X = XW'(TILE_SIDE);

    logic [TXW-1:0]     r_in_tile_x, r_in_tile_y, n_in_tile_x, n_in_tile_y;
    logic [TCW-1:0]     r_tile_col, r_tile_row, n_tile_col, n_tile_row;
    logic [COUNT_W-1:0] r_pixel_count, n_pixel_count;

    logic [TXW-1:0]     c_x, c_y;
    logic [TCW-1:0]     c_col, c_row;
    logic [COUNT_W-1:0] c_cnt;
    logic [XW-1:0]      px, py, wx, hx;
    logic               last;

    assign wx = XW'(i_width);
    assign hx = XW'(i_height);

    always_comb begin
        c_x   = i_restart ? '0 : r_in_tile_x;
        c_y   = i_restart ? '0 : r_in_tile_y;
        c_col = i_restart ? '0 : r_tile_col;
        c_row = i_restart ? '0 : r_tile_row;
        c_cnt = i_restart ? '0 : r_pixel_count;

        if ((TXW + 1)'(c_x) >= TS_T || (TXW + 1)'(c_y) >= TS_T) begin
            c_x   = '0;
            c_y   = '0;
            c_col = '0;
            c_row = '0;
            c_cnt = '0;
        end

        px = XW'(c_col) * TS_X + XW'(c_x);
        py = XW'(c_row) * TS_X + XW'(c_y);

        // position left outside a resized image: start over
        if (px >= wx || py >= hx) begin
            c_x   = '0;
            c_y   = '0;
            c_col = '0;
            c_row = '0;
            c_cnt = '0;
            px    = '0;
            py    = '0;
        end

        last = (px + XW'(1) == wx) && (py + XW'(1) == hx);

        n_in_tile_x   = c_x;
        n_in_tile_y   = c_y;
        n_tile_col    = c_col;
        n_tile_row    = c_row;
        n_pixel_count = c_cnt + COUNT_W'(1);

        if (last) begin
            n_in_tile_x   = '0;
            n_in_tile_y   = '0;
            n_tile_col    = '0;
            n_tile_row    = '0;
            n_pixel_count = '0;
        end else if ((TXW + 1)'(c_x) + (TXW + 1)'(1) < TS_T && px + XW'(1) < wx) begin
            n_in_tile_x = c_x + TXW'(1);
        end else if ((TXW + 1)'(c_y) + (TXW + 1)'(1) < TS_T && py + XW'(1) < hx) begin
            n_in_tile_x = '0;
            n_in_tile_y = c_y + TXW'(1);
        end else if ((XW'(c_col) + XW'(1)) * TS_X < wx) begin
            n_in_tile_x = '0;
            n_in_tile_y = '0;
            n_tile_col  = c_col + TCW'(1);
        end else begin
            n_in_tile_x = '0;
            n_in_tile_y = '0;
            n_tile_col  = '0;
            n_tile_row  = c_row + TCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tile_x   <= '0;
            r_in_tile_y   <= '0;
            r_tile_col    <= '0;
            r_tile_row    <= '0;
            r_pixel_count <= '0;
        end else if (i_step) begin
            r_in_tile_x   <= n_in_tile_x;
            r_in_tile_y   <= n_in_tile_y;
            r_tile_col    <= n_tile_col;
            r_tile_row    <= n_tile_row;
            r_pixel_count <= n_pixel_count;
        end
    end

    assign o_px    = px;
    assign o_py    = py;
    assign o_count = c_cnt;
    assign o_last  = last;

endmodule

// ===== src/ttag_chk.sv =====
// ----------------------------------------------------------------------------
// ttag_chk
// Port-level checks for the tiled texture address generator, bound to the
// top level. Shadows the configuration writes seen on the register port.
// ----------------------------------------------------------------------------
module ttag_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [ttag_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [ttag_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [ttag_pkg::CFG_DATA_W-1:0] prdata,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [ttag_pkg::OFFSET_W-1:0]   o_source_offset,
    input logic [ttag_pkg::OFFSET_W-1:0]   o_dest_offset,
    input logic                            o_last
);
    import ttag_pkg::*;

    logic [SIDE_REG_W-1:0] r_sh_width, r_sh_height;
    logic [BPP_W-1:0]      r_sh_bpp;
    t_reg_idx              idx;

    assign idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_width  <= WIDTH_RST;
            r_sh_height <= HEIGHT_RST;
            r_sh_bpp    <= BPP_RST;
        end else if (psel && penable && pwrite) begin
            if (idx == REG_IMAGE_WIDTH) begin
                r_sh_width <= pwdata[SIDE_REG_W-1:0];
            end
            if (idx == REG_IMAGE_HEIGHT) begin
                r_sh_height <= pwdata[SIDE_REG_W-1:0];
            end
            if (idx == REG_BYTES_PER_PIXEL) begin
                r_sh_bpp <= pwdata[BPP_W-1:0];
            end
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_source_offset)
            && $stable(o_dest_offset) && $stable(o_last))
        else $error("result beat changed while stalled");

    // four-byte pixels give word-aligned offsets on both sides
    a_bpp_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_sh_bpp >= BPP_MAX |->
            o_source_offset[1:0] == 2'b00 && o_dest_offset[1:0] == 2'b00)
        else $error("offset not aligned to pixel size");

    // a one-pixel image emits only its single, final pixel
    a_single_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_sh_width <= SIDE_REG_W'(1) && r_sh_height <= SIDE_REG_W'(1) |->
            o_last && o_source_offset == '0 && o_dest_offset == '0)
        else $error("one-pixel image gave a wrong pair");

    // width register reads back what was last written
    a_width_rdback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite && idx == REG_IMAGE_WIDTH |->
            prdata[SIDE_REG_W-1:0] == r_sh_width)
        else $error("width read-back mismatch");

endmodule

bind tiled_texture_address_generator ttag_chk u_ttag_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_source_offset (o_source_offset),
    .o_dest_offset   (o_dest_offset),
    .o_last          (o_last)
);

// ===== dv/ttag_checker.sv =====
// ----------------------------------------------------------------------------
// ttag_checker
// Watches the config port and both beat channels of the tiled texture address
// generator, tracks register writes, predicts every address pair from its own
// copy of the tile walk and compares each output beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module ttag_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [ttag_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ttag_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_restart,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [ttag_pkg::OFFSET_W-1:0]   i_source_offset,
    input  logic [ttag_pkg::OFFSET_W-1:0]   i_dest_offset,
    input  logic                            i_last,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_pair_count,
    output int                              o_last_count
);

    import ttag_pkg::*;

    localparam int unsigned TILE = TILE_SIDE_DEF;
    localparam int unsigned MAX  = MAX_SIDE_DEF;

    typedef struct packed {
        logic [OFFSET_W-1:0] source;
        logic [OFFSET_W-1:0] dest;
        logic                last;
    } t_addr_pair;

    logic [SIDE_REG_W-1:0] width_reg;
    logic [SIDE_REG_W-1:0] height_reg;
    logic [BPP_W-1:0]      bpp_reg;
    logic                  dir_reg;

    int unsigned           tile_x;
    int unsigned           tile_y;
    int unsigned           pix_x;
    int unsigned           pix_y;
    logic [COUNT_W-1:0]    tile_order_idx;

    t_addr_pair            expected_pairs[$];

    function automatic int unsigned clamp_side(input logic [SIDE_REG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX)
            return MAX;
        return v;
    endfunction

    task automatic rewind_walk();
        tile_x         = 0;
        tile_y         = 0;
        pix_x          = 0;
        pix_y          = 0;
        tile_order_idx = '0;
    endtask

    // Work out the pair for the current pixel, then step the tile walk.
    task automatic predict_pair(input logic restart_bit);
        int unsigned w;
        int unsigned h;
        int unsigned bpp;
        int unsigned px;
        int unsigned py;
        logic [OFFSET_W-1:0] lin;
        logic [OFFSET_W-1:0] til;
        logic at_end;
        t_addr_pair pair;

        w   = clamp_side(width_reg);
        h   = clamp_side(height_reg);
        bpp = (bpp_reg == 0) ? 1 : ((bpp_reg > BPP_MAX) ? BPP_MAX : bpp_reg);

        if (restart_bit)
            rewind_walk();

        px = tile_x * TILE + pix_x;
        py = tile_y * TILE + pix_y;
        // a shrunken image can leave the held position outside it
        if (px >= w || py >= h) begin
            rewind_walk();
            px = 0;
            py = 0;
        end

        lin    = OFFSET_W'((py * w + px) * bpp);
        til    = OFFSET_W'(tile_order_idx * bpp);
        at_end = (px + 1 == w) && (py + 1 == h);

        pair.source = dir_reg ? lin : til;
        pair.dest   = dir_reg ? til : lin;
        pair.last   = at_end;
        expected_pairs.push_back(pair);

        if (at_end) begin
            rewind_walk();
        end else begin
            tile_order_idx = tile_order_idx + 1'b1;
            if (pix_x + 1 < TILE && px + 1 < w) begin
                pix_x++;
            end else begin
                pix_x = 0;
                if (pix_y + 1 < TILE && py + 1 < h) begin
                    pix_y++;
                end else begin
                    pix_y = 0;
                    if ((tile_x + 1) * TILE < w) begin
                        tile_x++;
                    end else begin
                        tile_x = 0;
                        tile_y++;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_addr_pair exp_pair;
        logic       bad;

        if (!i_rst_n) begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            bpp_reg    = BPP_RST;
            dir_reg    = 1'b0;
            rewind_walk();
            expected_pairs.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_pair_count = 0;
            o_last_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[CFG_ADDR_W-1:2]))
                    REG_IMAGE_WIDTH:     width_reg  = pwdata[SIDE_REG_W-1:0];
                    REG_IMAGE_HEIGHT:    height_reg = pwdata[SIDE_REG_W-1:0];
                    REG_BYTES_PER_PIXEL: bpp_reg    = pwdata[BPP_W-1:0];
                    REG_DIRECTION:       dir_reg    = pwdata[0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready)
                predict_pair(i_restart);

            if (i_out_valid && i_out_ready) begin
                if (expected_pairs.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected pair, expected none actual src %0d dst %0d last %0b",
                             $time, i_source_offset, i_dest_offset, i_last);
                end else begin
                    exp_pair = expected_pairs.pop_front();
                    bad      = 1'b0;
                    if (i_source_offset !== exp_pair.source) begin
                        bad = 1'b1;
                        $display("%0t: source_offset mismatch, expected %0d actual %0d",
                                 $time, exp_pair.source, i_source_offset);
                    end
                    if (i_dest_offset !== exp_pair.dest) begin
                        bad = 1'b1;
                        $display("%0t: dest_offset mismatch, expected %0d actual %0d",
                                 $time, exp_pair.dest, i_dest_offset);
                    end
                    if (i_last !== exp_pair.last) begin
                        bad = 1'b1;
                        $display("%0t: last mismatch, expected %0b actual %0b",
                                 $time, exp_pair.last, i_last);
                    end
                    if (bad)
                        o_fail_count++;
                    o_pair_count++;
                    if (exp_pair.last)
                        o_last_count++;
                end
            end
            o_pending = expected_pairs.size();
        end
    end

endmodule

// ===== dv/tiled_texture_address_generator_tb.sv =====
// ----------------------------------------------------------------------------
// tiled_texture_address_generator_tb
// Drives restart/advance beats and register settings into the address
// generator, with random idling on both sides, a burst with no idling and a
// long output hold-off; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tiled_texture_address_generator_tb;

    import ttag_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int BURST_START  = 400;
    localparam int BURST_END    = 800;
    localparam int HOLD_START   = 1000;
    localparam int HOLD_CYCLES  = 200;
    localparam int TOTAL_BEATS  = 1150;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [CFG_DATA_W-1:0] pwdata     = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  in_restart = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [OFFSET_W-1:0]   source_offset;
    logic [OFFSET_W-1:0]   dest_offset;
    logic                  last_flag;

    int fail_count;
    int pending;
    int pair_count;
    int last_count;

    int beats_sent       = 0;
    int restarts_sent    = 0;
    int settings_applied = 0;
    int cycle_no         = 0;
    int rx_cycle         = 0;
    int hold_left        = 0;
    int stall_cycles     = 0;

    logic hold_done = 1'b0;

    always #4 i_clk = ~i_clk;

    tiled_texture_address_generator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_restart       (in_restart),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_source_offset (source_offset),
        .o_dest_offset   (dest_offset),
        .o_last          (last_flag)
    );

    ttag_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_restart       (in_restart),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_source_offset (source_offset),
        .i_dest_offset   (dest_offset),
        .i_last          (last_flag),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_pair_count    (pair_count),
        .o_last_count    (last_count)
    );

    always @(posedge i_clk)
        cycle_no <= cycle_no + 1;

    // Receiver: random stalls, one burst with no stall, one long hold-off that
    // starts while the sender is offering a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_cycle  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (!hold_done && rx_cycle >= HOLD_START && in_valid) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (rx_cycle >= BURST_START && rx_cycle < BURST_END)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 32);
        end
    end

    // Abort when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_beat(input logic restart_bit);
        in_valid   <= 1'b1;
        in_restart <= restart_bit;
        do @(posedge i_clk); while (!in_ready);
        beats_sent++;
        if (restart_bit)
            restarts_sent++;
        if (!(cycle_no >= BURST_START && cycle_no < BURST_END)) begin
            while ($urandom_range(99) < 32) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic apply_config(input int unsigned w, input int unsigned h,
                                input int unsigned bpp, input int unsigned dir);
        in_valid <= 1'b0;
        wait_drained();
        // let the pipeline stages behind the last pair settle
        repeat (4) @(posedge i_clk);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_BYTES_PER_PIXEL, bpp);
        write_reg(REG_DIRECTION, dir);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_applied++;
    endtask

    function automatic int unsigned extreme_side();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 1;
            2:       return MAX_SIDE_DEF;
            3:       return $urandom_range(MAX_SIDE_DEF + 1, 8190);
            4:       return 8191;
            default: return MAX_SIDE_DEF - 1;
        endcase
    endfunction

    initial begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned phase_beats;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting is a single pixel: every beat is the final one.
        send_beat(1'b0);
        send_beat(1'b0);
        send_beat(1'b1);

        // Small image inside one tile: restart mid-walk.
        apply_config(3, 2, 3, 1);
        repeat (4) send_beat(1'b0);
        send_beat(1'b1);
        repeat (3) send_beat(1'b0);

        // Drop a row under the held position: walk must start over.
        apply_config(3, 1, 3, 1);
        repeat (2) send_beat(1'b0);

        // Zero and oversize sides, out-of-range pixel sizes.
        apply_config(0, 8191, 0, 0);
        repeat (3) send_beat(1'b0);
        apply_config(8191, 0, 7, 1);
        repeat (3) send_beat(1'b0);

        while (beats_sent < TOTAL_BEATS) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    w = $urandom_range(1, 70);
                    h = $urandom_range(1, 4);
                end
                6, 7: begin
                    w = $urandom_range(1, 6);
                    h = $urandom_range(20, 80);
                end
                8: begin
                    w = $urandom_range(30, 35);
                    h = $urandom_range(30, 35);
                end
                default: begin
                    w = extreme_side();
                    h = extreme_side();
                end
            endcase
            apply_config(w, h, $urandom_range(7), $urandom_range(1));
            phase_beats = $urandom_range(50, 130);
            if (phase_beats > TOTAL_BEATS - beats_sent)
                phase_beats = TOTAL_BEATS - beats_sent;
            repeat (phase_beats) send_beat($urandom_range(39) == 0);
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        $display("Sent %0d beats (%0d restarts) across %0d register settings.",
                 beats_sent, restarts_sent, settings_applied);
        $display("Compared %0d address pairs, %0d of them closing an image.",
                 pair_count, last_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
